>>> sv/assert_macros.svh
// Assertion macros shared by the page allocator RTL.
// No dependencies; each macro compiles to nothing when SYNTHESIS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPFL_ASSERT(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");
`define PPFL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");
`define PPFL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");
`else
`define PPFL_ASSERT(label, clk, rst, cond)
`define PPFL_ASSERT_IMP(label, clk, rst, ante, cons)
`define PPFL_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/ppfl_pkg.sv
// Types and fixed constants of the page free-list allocator.
// No dependencies; imported by the controller and the top level.
`timescale 1ns / 1ps

package ppfl_pkg;

   localparam int CMD_W      = 2;
   localparam int PAGE_W     = 12;
   localparam int PTYPE_W    = 4;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 13;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_SET     = 2'd2,
      CMD_REBUILD = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ALLOC,
      S_SCAN,
      S_TAIL,
      S_DONE
   } state_type;

   // register index, taken from paddr[2]
   localparam logic REG_PAGES_PRESENT = 1'b0;
   localparam logic REG_FREE_TYPE     = 1'b1;

   typedef struct packed {
      logic [COUNT_W-1:0] pages_present;
      logic [PTYPE_W-1:0] free_type_code;
   } csr_cfg_type;

endpackage

>>> sv/ppfl_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps

module ppfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/ppfl_ctrl.sv
// Sequencer and datapath of the page allocator: list head, free count,
// rebuild scan over the entry table and the result register.
// Depends on ppfl_pkg and assert_macros.svh; drives two ppfl_ram instances.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ppfl_ctrl #(
   parameter int PAGES     = 4096,
   parameter int TYPE_BITS = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ppfl_pkg::csr_cfg_type              cfg,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [ppfl_pkg::CMD_W-1:0]         req_cmd,
   input  logic [ppfl_pkg::PAGE_W-1:0]        req_page,
   input  logic [ppfl_pkg::PTYPE_W-1:0]       req_page_type,
   input  logic                               req_system_page,
   input  logic                               req_set_mapped,
   input  logic                               req_set_pageable,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ppfl_pkg::PAGE_W-1:0]        rsp_result_page,
   output logic [ppfl_pkg::STATUS_W-1:0]      rsp_status,
   output logic [ppfl_pkg::COUNT_W-1:0]       rsp_free_count,
   output logic                               link_we,
   output logic [$clog2(PAGES)-1:0]           link_waddr,
   output logic [$clog2(PAGES)-1:0]           link_wdata,
   output logic [$clog2(PAGES)-1:0]           link_raddr,
   input  logic [$clog2(PAGES)-1:0]           link_rdata,
   output logic                               entry_we,
   output logic [$clog2(PAGES)-1:0]           entry_waddr,
   output logic [TYPE_BITS+2:0]               entry_wdata,
   output logic [$clog2(PAGES)-1:0]           entry_raddr,
   input  logic [TYPE_BITS+2:0]               entry_rdata
);

   import ppfl_pkg::*;

   localparam int ADDR_W  = $clog2(PAGES);
   localparam int CNT_W   = $clog2(PAGES + 1);
   localparam int LIM_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam int CMP_W   = (TYPE_BITS > PTYPE_W) ? TYPE_BITS : PTYPE_W;

   state_type              state_ff, state_in;
   logic [LIM_W-1:0]       scan_ff, scan_in;
   logic [ADDR_W-1:0]      head_ff, head_in;
   logic [CNT_W-1:0]       total_ff, total_in;
   logic [ADDR_W-1:0]      last_ff, last_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [ADDR_W-1:0]      chk_page_ff, chk_page_in;
   logic [TYPE_BITS-1:0]   ptype_ff, ptype_in;
   logic                   sys_ff, sys_in;
   logic [ADDR_W-1:0]      res_page_ff, res_page_in;
   status_type             res_status_ff, res_status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]      rsp_page_ff, rsp_page_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   cmd_type                cmd;
   logic                   accept;
   logic [LIM_W-1:0]       lim;
   logic [LIM_W-1:0]       pp_ext;
   logic                   page_ok;
   logic                   free_ok;
   logic [ADDR_W-1:0]      req_addr;
   logic [ADDR_W-1:0]      scan_addr;
   logic                   scan_issue;
   logic                   type_match;
   logic                   slot_free;
   logic                   clear_last;

   assign cmd        = cmd_type'(req_cmd);
   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign pp_ext     = LIM_W'(cfg.pages_present);
   assign lim        = (pp_ext < LIM_W'(PAGES)) ? pp_ext : LIM_W'(PAGES);
   assign page_ok    = LIM_W'(req_page) < lim;
   assign free_ok    = page_ok && (req_page != '0);
   assign req_addr   = ADDR_W'(req_page);
   assign scan_addr  = ADDR_W'(scan_ff);
   assign scan_issue = (state_ff == S_SCAN) && (scan_ff < lim);
   // the one compare unit: stored type against the free code
   assign type_match = CMP_W'(entry_rdata[TYPE_BITS+2:3]) == CMP_W'(cfg.free_type_code);
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign clear_last = scan_ff == LIM_W'(PAGES - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (cmd)
                  CMD_ALLOC:   state_in = (head_ff == '0) ? S_DONE : S_ALLOC;
                  CMD_REBUILD: state_in = S_SCAN;
                  CMD_FREE:    state_in = S_DONE;
                  CMD_SET:     state_in = S_DONE;
               endcase
            end
         end
         S_ALLOC: state_in = S_DONE;
         S_SCAN: begin
            if (!scan_issue && !chk_vld_ff) state_in = S_TAIL;
         end
         S_TAIL: state_in = S_DONE;
         S_DONE: begin
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // memory port controls
   always_comb begin
      link_we     = 1'b0;
      link_waddr  = head_ff;
      link_wdata  = '0;
      link_raddr  = head_ff;
      entry_we    = 1'b0;
      entry_waddr = head_ff;
      entry_wdata = '0;
      entry_raddr = scan_addr;
      unique case (state_ff)
         S_CLEAR: begin
            link_we     = 1'b1;
            link_waddr  = scan_addr;
            entry_we    = 1'b1;
            entry_waddr = scan_addr;
         end
         S_IDLE: begin
            if (accept && cmd == CMD_FREE && free_ok) begin
               link_we     = 1'b1;
               link_waddr  = req_addr;
               link_wdata  = head_ff;
               entry_we    = 1'b1;
               entry_waddr = req_addr;
               entry_wdata = {TYPE_BITS'(cfg.free_type_code), 3'b000};
            end else if (accept && cmd == CMD_SET && page_ok) begin
               entry_we    = 1'b1;
               entry_waddr = req_addr;
               entry_wdata = {TYPE_BITS'(req_page_type), req_set_mapped,
                              req_set_pageable, 1'b0};
            end
         end
         S_ALLOC: begin
            link_we     = 1'b1;
            entry_we    = 1'b1;
            entry_wdata = {ptype_ff, 1'b1, !sys_ff, 1'b0};
         end
         S_SCAN: begin
            // chain the found page behind the previous one
            if (chk_vld_ff && type_match && last_ff != '0) begin
               link_we    = 1'b1;
               link_waddr = last_ff;
               link_wdata = chk_page_ff;
            end
         end
         S_TAIL: begin
            if (last_ff != '0) begin
               link_we    = 1'b1;
               link_waddr = last_ff;
            end
         end
         S_DONE: begin
            link_we = 1'b0;
         end
         default: begin
            link_we = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      scan_in       = scan_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      last_in       = last_ff;
      chk_vld_in    = scan_issue;
      chk_page_in   = scan_addr;
      ptype_in      = ptype_ff;
      sys_in        = sys_ff;
      res_page_in   = res_page_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_page_in   = rsp_page_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      unique case (state_ff)
         S_CLEAR: scan_in = scan_ff + 1'b1;
         S_IDLE: begin
            if (accept) begin
               ptype_in      = TYPE_BITS'(req_page_type);
               sys_in        = req_system_page;
               res_page_in   = '0;
               res_status_in = STS_OK;
               unique case (cmd)
                  CMD_ALLOC: begin
                     if (head_ff == '0) res_status_in = STS_EMPTY;
                  end
                  CMD_FREE: begin
                     if (free_ok) begin
                        head_in  = req_addr;
                        total_in = (total_ff == CNT_W'(PAGES)) ? total_ff
                                                               : total_ff + 1'b1;
                     end else begin
                        res_status_in = STS_RANGE;
                     end
                  end
                  CMD_SET: begin
                     if (!page_ok) res_status_in = STS_RANGE;
                  end
                  CMD_REBUILD: begin
                     head_in  = '0;
                     last_in  = '0;
                     total_in = '0;
                     scan_in  = LIM_W'(1);
                  end
               endcase
            end
         end
         S_ALLOC: begin
            head_in     = link_rdata;
            total_in    = (total_ff != '0) ? total_ff - 1'b1 : total_ff;
            res_page_in = head_ff;
         end
         S_SCAN: begin
            if (scan_issue) scan_in = scan_ff + 1'b1;
            if (chk_vld_ff && type_match) begin
               if (last_ff == '0) head_in = chk_page_ff;
               last_in  = chk_page_ff;
               total_in = total_ff + 1'b1;
            end
         end
         S_TAIL: last_in = last_ff;
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_page_in   = PAGE_W'(res_page_ff);
               rsp_status_in = res_status_ff;
               rsp_count_in  = COUNT_W'(total_ff);
            end
         end
         default: scan_in = scan_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_ff      <= '0;
         head_ff      <= '0;
         total_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         head_ff      <= head_in;
         total_ff     <= total_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff       <= last_in;
      chk_page_ff   <= chk_page_in;
      ptype_ff      <= ptype_in;
      sys_ff        <= sys_in;
      res_page_ff   <= res_page_in;
      res_status_ff <= res_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_page = rsp_page_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_free_count  = rsp_count_ff;

   `PPFL_ASSERT(a_head_in_range, clock, reset, LIM_W'(head_ff) < LIM_W'(PAGES))
   `PPFL_ASSERT(a_total_capped, clock, reset, total_ff <= CNT_W'(PAGES))
   `PPFL_ASSERT_IMP(a_scan_skips_zero, clock, reset, chk_vld_ff, chk_page_ff != '0)
   `PPFL_ASSERT_NXT(a_done_delivers, clock, reset, state_ff == S_DONE && slot_free,
                    rsp_valid_ff && state_ff == S_IDLE)

endmodule

>>> sv/physical_page_free_list_allocator_unit.sv
// Top level of the physical page free-list allocator: register port,
// sequencer and the link and entry tables.
// Depends on ppfl_pkg, ppfl_ctrl and ppfl_ram.
//
//   channel   ports      direction   moves
//   req       req_*      in          one request: command, page, type, flags
//   rsp       rsp_*      out         one result per request
//   csr       csr_*      in/out      pages_present at 0x0, free_type_code at 0x4
//
// Free and set entry write the tables as the request is accepted; allocate
// does one registered read of the head page's link, then the writes, and on
// an empty list goes straight to its result. Rebuild scans from page 1 up to
// below the limit: the sequencer reads one entry a cycle through the type compare.
// After reset a clearing pass over all PAGES entries zeroes both tables;
// requests are held off until it ends, register writes are taken throughout.
// A result waiting in the output register blocks only the end of the next
// request, not its acceptance.
`timescale 1ns / 1ps

module physical_page_free_list_allocator_unit #(
   parameter int PAGES     = 4096,
   parameter int TYPE_BITS = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ppfl_pkg::CMD_W-1:0]          req_cmd,
   input  logic [ppfl_pkg::PAGE_W-1:0]         req_page,
   input  logic [ppfl_pkg::PTYPE_W-1:0]        req_page_type,
   input  logic                                req_system_page,
   input  logic                                req_set_mapped,
   input  logic                                req_set_pageable,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ppfl_pkg::PAGE_W-1:0]         rsp_result_page,
   output logic [ppfl_pkg::STATUS_W-1:0]       rsp_status,
   output logic [ppfl_pkg::COUNT_W-1:0]        rsp_free_count,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ppfl_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [ppfl_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [ppfl_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import ppfl_pkg::*;

   localparam int ADDR_W  = $clog2(PAGES);
   localparam int ENTRY_W = TYPE_BITS + 3;

   csr_cfg_type          cfg_ff, cfg_in;
   logic                 csr_wr;

   logic                 link_we;
   logic [ADDR_W-1:0]    link_waddr;
   logic [ADDR_W-1:0]    link_wdata;
   logic [ADDR_W-1:0]    link_raddr;
   logic [ADDR_W-1:0]    link_rdata;
   logic                 entry_we;
   logic [ADDR_W-1:0]    entry_waddr;
   logic [ENTRY_W-1:0]   entry_wdata;
   logic [ADDR_W-1:0]    entry_raddr;
   logic [ENTRY_W-1:0]   entry_rdata;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // byte offset ignored; paddr[2] picks the register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_PAGES_PRESENT: cfg_in.pages_present  = csr_pwdata[COUNT_W-1:0];
            REG_FREE_TYPE:     cfg_in.free_type_code = csr_pwdata[PTYPE_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_PAGES_PRESENT: csr_prdata = CSR_DATA_W'(cfg_ff.pages_present);
         REG_FREE_TYPE:     csr_prdata = CSR_DATA_W'(cfg_ff.free_type_code);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pages_present  <= COUNT_W'(4096);
         cfg_ff.free_type_code <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ppfl_ctrl #(
      .PAGES     (PAGES),
      .TYPE_BITS (TYPE_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_page         (req_page),
      .req_page_type    (req_page_type),
      .req_system_page  (req_system_page),
      .req_set_mapped   (req_set_mapped),
      .req_set_pageable (req_set_pageable),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_page  (rsp_result_page),
      .rsp_status       (rsp_status),
      .rsp_free_count   (rsp_free_count),
      .link_we          (link_we),
      .link_waddr       (link_waddr),
      .link_wdata       (link_wdata),
      .link_raddr       (link_raddr),
      .link_rdata       (link_rdata),
      .entry_we         (entry_we),
      .entry_waddr      (entry_waddr),
      .entry_wdata      (entry_wdata),
      .entry_raddr      (entry_raddr),
      .entry_rdata      (entry_rdata)
   );

   ppfl_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (PAGES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   // entry word: type, mapped, pageable, in page-out buffer
   ppfl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PAGES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (entry_waddr),
      .wr_data (entry_wdata),
      .rd_addr (entry_raddr),
      .rd_data (entry_rdata)
   );

endmodule

>>> sim/tb.sv
// Self-checking bench for the page free-list allocator: random and directed requests,
// register changes between phases, results checked against a free-list predictor.
// Depends on ppfl_pkg and physical_page_free_list_allocator_unit.
`timescale 1ns / 1ps

module tb;
   import ppfl_pkg::*;

   localparam int NUM_PAGES      = 4096;
   localparam int STALL_MAX      = 10;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 16;

   typedef struct {
      logic [PAGE_W-1:0]  page;
      status_type         status;
      logic [COUNT_W-1:0] count;
   } alloc_result_type;

   class free_list_model;
      logic [PAGE_W-1:0]  link_tbl [NUM_PAGES];
      logic [PTYPE_W-1:0] type_tbl [NUM_PAGES];
      logic [PAGE_W-1:0]  head;
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] pages_present;
      logic [PTYPE_W-1:0] free_type;
      alloc_result_type   pending [$];
      int                 failures;

      function new();
         foreach (link_tbl[i]) begin
            link_tbl[i] = '0;
            type_tbl[i] = '0;
         end
         head          = '0;
         total         = '0;
         pages_present = 13'd4096;
         free_type     = '0;
         failures      = 0;
      endfunction

      function int limit();
         return (pages_present < NUM_PAGES) ? int'(pages_present) : NUM_PAGES;
      endfunction

      function void note_request(cmd_type cmd, logic [PAGE_W-1:0] page,
                                 logic [PTYPE_W-1:0] ptype);
         alloc_result_type res;
         int               last;
         res.page   = '0;
         res.status = STS_OK;
         case (cmd)
            CMD_ALLOC: begin
               if (head == '0) begin
                  res.status = STS_EMPTY;
               end else begin
                  res.page = head;
                  head = link_tbl[res.page];
                  link_tbl[res.page] = '0;
                  type_tbl[res.page] = ptype;
                  if (total != '0) total--;
               end
            end
            CMD_FREE: begin
               // page 0 terminates the list and can never be pushed
               if (page == '0 || page >= limit()) begin
                  res.status = STS_RANGE;
               end else begin
                  type_tbl[page] = free_type;
                  link_tbl[page] = head;
                  head = page;
                  if (total < NUM_PAGES) total++;
               end
            end
            CMD_SET: begin
               if (page >= limit()) res.status = STS_RANGE;
               else type_tbl[page] = ptype;
            end
            default: begin
               head  = '0;
               total = '0;
               last  = 0;
               for (int p = 1; p < limit(); p++) begin
                  if (type_tbl[p] == free_type) begin
                     if (last == 0) head = PAGE_W'(p);
                     else link_tbl[last] = PAGE_W'(p);
                     link_tbl[p] = '0;
                     last = p;
                     total++;
                  end
               end
            end
         endcase
         res.count = total;
         pending.push_back(res);
      endfunction

      function void check_result(logic [PAGE_W-1:0] page, logic [STATUS_W-1:0] status,
                                 logic [COUNT_W-1:0] count);
         alloc_result_type want;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("%0t: result with nothing outstanding: page %0d status %0d count %0d",
                        $time, page, status, count);
            return;
         end
         want = pending.pop_front();
         if (page !== want.page || status !== want.status || count !== want.count) begin
            failures++;
            if (failures <= 10)
               $display("%0t: expected page %0d status %0d count %0d, got %0d %0d %0d",
                        $time, want.page, want.status, want.count, page, status, count);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_cmd;
   logic [PAGE_W-1:0]     req_page;
   logic [PTYPE_W-1:0]    req_page_type;
   logic                  req_system_page;
   logic                  req_set_mapped;
   logic                  req_set_pageable;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [PAGE_W-1:0]     rsp_result_page;
   logic [STATUS_W-1:0]   rsp_status;
   logic [COUNT_W-1:0]    rsp_free_count;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   free_list_model sb;
   bit             no_idle = 1'b0;
   int             quiet_cycles = 0;

   physical_page_free_list_allocator_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_page         (req_page),
      .req_page_type    (req_page_type),
      .req_system_page  (req_system_page),
      .req_set_mapped   (req_set_mapped),
      .req_set_pageable (req_set_pageable),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_page  (rsp_result_page),
      .rsp_status       (rsp_status),
      .rsp_free_count   (rsp_free_count),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   // result side: random stall before each result, then hold ready until it is taken
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
         sb.check_result(rsp_result_page, rsp_status, rsp_free_count);
         @(negedge clock);
      end
   end

   task automatic send_request(cmd_type cmd, logic [PAGE_W-1:0] page,
                               logic [PTYPE_W-1:0] ptype, logic sys, logic map, logic pag);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, STALL_MAX);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd          <= cmd;
      req_page         <= page;
      req_page_type    <= ptype;
      req_system_page  <= sys;
      req_set_mapped   <= map;
      req_set_pageable <= pag;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_request(cmd, page, ptype);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_DATA_W-1:0] value);
      wait_drained();
      repeat (4) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_PAGES_PRESENT) sb.pages_present = value[COUNT_W-1:0];
      else sb.free_type = value[PTYPE_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // mostly near the managed range, now and then anywhere
   function automatic logic [PAGE_W-1:0] pick_page();
      int hi;
      hi = sb.limit() + 1;
      if (hi > NUM_PAGES - 1) hi = NUM_PAGES - 1;
      if ($urandom_range(0, 9) == 0) return PAGE_W'($urandom_range(0, NUM_PAGES - 1));
      return PAGE_W'($urandom_range(0, hi));
   endfunction

   task automatic run_directed();
      // allocate on the empty list after reset
      send_request(CMD_ALLOC, 12'hFFF, 4'hF, 1'b1, 1'b1, 1'b1);
      send_request(CMD_FREE, 12'd0, 4'h0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_FREE, 12'd4095, 4'h0, 1'b1, 1'b0, 1'b1);
      send_request(CMD_SET, 12'd4095, 4'hF, 1'b0, 1'b1, 1'b1);
      send_request(CMD_SET, 12'd0, 4'hF, 1'b1, 1'b0, 1'b0);
      send_request(CMD_ALLOC, 12'd0, 4'hA, 1'b1, 1'b0, 1'b0);
      send_request(CMD_ALLOC, 12'd2048, 4'h5, 1'b0, 1'b1, 1'b1);
      send_request(CMD_REBUILD, 12'd1, 4'h3, 1'b0, 1'b0, 1'b0);
      send_request(CMD_ALLOC, 12'd0, 4'h1, 1'b0, 1'b0, 1'b0);
      send_request(CMD_ALLOC, 12'd0, 4'h2, 1'b1, 1'b0, 1'b0);
      // free the same page twice: the list loops on itself
      send_request(CMD_FREE, 12'd1, 4'h0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_FREE, 12'd1, 4'hF, 1'b0, 1'b1, 1'b1);
      send_request(CMD_ALLOC, 12'd0, 4'h7, 1'b0, 1'b0, 1'b0);
      send_request(CMD_ALLOC, 12'd0, 4'h7, 1'b0, 1'b0, 1'b0);
      send_request(CMD_ALLOC, 12'd0, 4'h7, 1'b0, 1'b0, 1'b0);
      // no pages installed: every free and set entry is out of range
      write_csr(REG_PAGES_PRESENT, 32'd0);
      send_request(CMD_FREE, 12'd1, 4'h0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_SET, 12'd0, 4'h4, 1'b0, 1'b1, 1'b0);
      send_request(CMD_REBUILD, 12'd0, 4'h0, 1'b0, 1'b0, 1'b0);
      send_request(CMD_ALLOC, 12'd0, 4'h0, 1'b0, 1'b0, 1'b0);
      write_csr(REG_PAGES_PRESENT, 32'd8191);
      write_csr(REG_FREE_TYPE, 32'd15);
      send_request(CMD_SET, 12'd4095, 4'hF, 1'b0, 1'b0, 1'b1);
      send_request(CMD_FREE, 12'd4095, 4'h2, 1'b0, 1'b0, 1'b0);
      send_request(CMD_REBUILD, 12'd4095, 4'hF, 1'b1, 1'b1, 1'b1);
      send_request(CMD_ALLOC, 12'd0, 4'hC, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic run_random(logic [CSR_DATA_W-1:0] present, logic [CSR_DATA_W-1:0] ftype,
                             int n_items);
      int                 i;
      int                 r;
      cmd_type            cmd;
      logic [PTYPE_W-1:0] ptype;
      write_csr(REG_PAGES_PRESENT, present);
      write_csr(REG_FREE_TYPE, ftype);
      // seed some types, then build the list from them
      repeat (6) begin
         ptype = $urandom_range(0, 1) ? ftype[PTYPE_W-1:0] : PTYPE_W'($urandom_range(0, 15));
         send_request(CMD_SET, pick_page(), ptype, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      send_request(CMD_REBUILD, pick_page(), PTYPE_W'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      i = 0;
      while (i < n_items) begin
         if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (i == n_items / 2) wait_drained();
         r = $urandom_range(0, 99);
         if (r < 3) begin
            wait_drained();
            continue;
         end
         ptype = PTYPE_W'($urandom_range(0, 15));
         if (r < 42) begin
            cmd = CMD_ALLOC;
         end else if (r < 72) begin
            cmd = CMD_FREE;
         end else if (r < 93) begin
            cmd = CMD_SET;
            if ($urandom_range(0, 1)) ptype = ftype[PTYPE_W-1:0];
         end else begin
            // long scans only on small tables
            cmd = (sb.limit() <= 600) ? CMD_REBUILD : CMD_ALLOC;
         end
         send_request(cmd, pick_page(), ptype, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         i++;
      end
   endtask

   initial begin
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_ALLOC;
      req_page         = '0;
      req_page_type    = '0;
      req_system_page  = 1'b0;
      req_set_mapped   = 1'b0;
      req_set_pageable = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(32'd2, 32'd15, 80);
      run_random(32'd1, 32'd3, 60);
      run_random(32'd17, 32'd0, 90);
      run_random(32'd64, 32'd7, 90);
      run_random(32'd300, 32'd5, 90);
      run_random(32'd4096, 32'd15, 90);
      run_random(32'd40, 32'd9, 90);
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.failures == 0 && sb.pending.size() == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule

>>> sim.f
+incdir+sv
sv/ppfl_pkg.sv
sv/ppfl_ram.sv
sv/ppfl_ctrl.sv
sv/physical_page_free_list_allocator_unit.sv
sim/tb.sv
